/* hw/rtl/otsu_pkg.sv */
// Shared constants for the Otsu threshold block.
// No dependencies; used by the top level and the serial multiplier.
package otsu_pkg;
    localparam int BIN_N  = 256;
    localparam int BIN_W  = 8;
    localparam int CNT_W  = 21;
    localparam int SUM_W  = CNT_W + BIN_W;
    localparam int DIFF_W = SUM_W + CNT_W;
    localparam int DEN_W  = 2 * CNT_W;
    localparam int MC_W   = 2 * DIFF_W;
    localparam int MP_W   = DIFF_W;
    localparam int PROD_W = MC_W + MP_W;
    localparam int TSUM_W = 15;
    localparam int TCNT_W = 9;
    localparam logic [CNT_W-1:0] CAP = {CNT_W{1'b1}};
endpackage

/* hw/rtl/otsu_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module otsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/otsu_smul.sv */
// Shift-add serial multiplier, one multiplier bit per cycle.
// Depends on otsu_pkg for operand widths.
module otsu_smul import otsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MC_W-1:0]   i_mcand,
    input  logic [MP_W-1:0]   i_mplier,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);
    localparam int CW = $clog2(MP_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [PROD_W-1:0] r_mc, n_mc;
    logic [MP_W-1:0]   r_mp, n_mp;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mp   = r_mp;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(MP_W - 1);
            n_acc  = '0;
            n_mc   = PROD_W'(i_mcand);
            n_mp   = i_mplier;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                n_acc = r_acc + r_mc;
            end
            n_mc  = {r_mc[PROD_W-2:0], 1'b0};
            n_mp  = {1'b0, r_mp[MP_W-1:1]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

/* hw/rtl/otsu_threshold_from_histogram_top.sv */
// Otsu threshold from a 256-bin histogram; uses otsu_pkg, otsu_ram, otsu_smul.
// Throughput: one pixel per cycle while a frame streams in (histogram RAM RMW with forwarding).
// After the frame-end transaction: a drain state, then per bin the control states and three
// serial multiplies, then a 15-bit restoring division and a done state; an overflowed frame
// only walks the bins, with no multiplies or division. No pixel is accepted during the scan.
// Reset: synchronous, active low; a clearing pass over all 256 bins zeroes the histogram, no
// pixel is accepted during it. Bins are zeroed again by the scan after every frame.
module otsu_threshold_from_histogram_top import otsu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [BIN_W-1:0] i_pixel,
    input  logic             i_frame_end,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [BIN_W-1:0] o_threshold,
    output logic             o_overflow
);
    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DRAIN = 4'd2;
    localparam logic [3:0] ST_RD    = 4'd3;
    localparam logic [3:0] ST_HK    = 4'd4;
    localparam logic [3:0] ST_AB    = 4'd5;
    localparam logic [3:0] ST_DEN   = 4'd6;
    localparam logic [3:0] ST_M1    = 4'd7;
    localparam logic [3:0] ST_M2    = 4'd8;
    localparam logic [3:0] ST_M3    = 4'd9;
    localparam logic [3:0] ST_CMP   = 4'd10;
    localparam logic [3:0] ST_DIV   = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    logic [3:0] r_state, n_state;
    logic [BIN_W-1:0] r_k, n_k;

    // frame statistics
    logic [CNT_W-1:0] r_tot, n_tot;
    logic [SUM_W-1:0] r_isum, n_isum;
    logic             r_ovf, n_ovf;

    // histogram update pipeline
    logic             r_s1_vld, n_s1_vld;
    logic [BIN_W-1:0] r_s1_addr;
    logic             r_w_vld;
    logic [BIN_W-1:0] r_w_addr;
    logic [CNT_W-1:0] r_w_data;

    // scan working registers
    logic [CNT_W-1:0]  r_c, n_c;
    logic [SUM_W-1:0]  r_s, n_s;
    logic [DIFF_W-1:0] r_a, n_a, r_b, n_b;
    logic [CNT_W-1:0]  r_nc, n_nc;
    logic [DIFF_W-1:0] r_diff, n_diff;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [MC_W-1:0]   r_d2, n_d2;
    logic [PROD_W-1:0] r_lhs, n_lhs;
    logic [PROD_W-1:0] r_rhs, n_rhs;
    logic [MC_W-1:0]   r_best_d2, n_best_d2;
    logic [DEN_W-1:0]  r_best_den, n_best_den;
    logic [TSUM_W-1:0] r_tsum, n_tsum;
    logic [TCNT_W-1:0] r_tcnt, n_tcnt;
    logic              r_go, n_go;

    // divider
    logic [TSUM_W-1:0] r_q, n_q;
    logic [TCNT_W:0]   r_rem, n_rem;
    logic [TCNT_W:0]   div_sh;

    // output register
    logic             r_out_vld, n_out_vld;
    logic [BIN_W-1:0] r_thr, n_thr;
    logic             r_oflag, n_oflag;

    // RAM and multiplier hookup
    logic             ram_we;
    logic [BIN_W-1:0] ram_waddr, ram_raddr;
    logic [CNT_W-1:0] ram_wdata, ram_rdata, bin_inc;
    logic [MC_W-1:0]  mul_mc;
    logic [MP_W-1:0]  mul_mp;
    logic             mul_done;
    logic [PROD_W-1:0] mul_prod;
    logic             acc_in;

    assign o_ready  = (r_state == ST_IDLE);
    assign acc_in   = i_valid && o_ready;
    assign o_valid  = r_out_vld;
    assign o_threshold = r_thr;
    assign o_overflow  = r_oflag;

    // Forward last cycle's write when the same bin is hit back to back.
    assign bin_inc = ((r_w_vld && r_w_addr == r_s1_addr) ? r_w_data : ram_rdata) + 1'b1;

    always_comb begin
        ram_raddr = (r_state == ST_IDLE) ? i_pixel : r_k;
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = '0;
        if (r_s1_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_s1_addr;
            ram_wdata = bin_inc;
        end else if (r_state == ST_CLR || r_state == ST_HK) begin
            ram_we    = 1'b1;
        end
    end

    otsu_ram #(.WIDTH(CNT_W), .DEPTH(BIN_N)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        mul_mc = MC_W'(r_diff);
        mul_mp = r_diff;
        case (r_state)
            ST_M2: begin
                mul_mc = r_d2;
                mul_mp = MP_W'(r_best_den);
            end
            ST_M3: begin
                mul_mc = r_best_d2;
                mul_mp = MP_W'(r_den);
            end
            default: begin
                mul_mc = MC_W'(r_diff);
                mul_mp = r_diff;
            end
        endcase
    end

    otsu_smul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_go),
        .i_mcand  (mul_mc),
        .i_mplier (mul_mp),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    assign div_sh = {r_rem[TCNT_W-1:0], r_q[TSUM_W-1]};

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_tot      = r_tot;
        n_isum     = r_isum;
        n_ovf      = r_ovf;
        n_s1_vld   = 1'b0;
        n_c        = r_c;
        n_s        = r_s;
        n_a        = r_a;
        n_b        = r_b;
        n_nc       = r_nc;
        n_diff     = r_diff;
        n_den      = r_den;
        n_d2       = r_d2;
        n_lhs      = r_lhs;
        n_rhs      = r_rhs;
        n_best_d2  = r_best_d2;
        n_best_den = r_best_den;
        n_tsum     = r_tsum;
        n_tcnt     = r_tcnt;
        n_go       = 1'b0;
        n_q        = r_q;
        n_rem      = r_rem;
        n_out_vld  = r_out_vld && !i_ready;
        n_thr      = r_thr;
        n_oflag    = r_oflag;

        case (r_state)
            ST_CLR: begin
                n_k = r_k + 1'b1;
                if (r_k == BIN_W'(BIN_N - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc_in) begin
                    if (r_tot == CAP) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_s1_vld = 1'b1;
                        n_tot    = r_tot + 1'b1;
                        n_isum   = r_isum + SUM_W'(i_pixel);
                    end
                    if (i_frame_end) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // last histogram write lands this cycle; start the bin walk
                n_k        = '0;
                n_c        = '0;
                n_s        = '0;
                n_best_d2  = '0;
                n_best_den = DEN_W'(1);
                n_tsum     = '0;
                n_tcnt     = '0;
                n_state    = ST_RD;
            end
            ST_RD: begin
                n_state = ST_HK;
            end
            ST_HK: begin
                n_c = r_c + ram_rdata;
                n_s = r_s + SUM_W'(ram_rdata) * SUM_W'(r_k);
                if (r_ovf) begin
                    n_k     = r_k + 1'b1;
                    n_state = (r_k == BIN_W'(BIN_N - 1)) ? ST_DONE : ST_RD;
                end else begin
                    n_state = ST_AB;
                end
            end
            ST_AB: begin
                n_a     = DIFF_W'(r_isum) * DIFF_W'(r_c);
                n_b     = DIFF_W'(r_s) * DIFF_W'(r_tot);
                n_nc    = r_tot - r_c;
                n_state = ST_DEN;
            end
            ST_DEN: begin
                if (r_c == '0 || r_c == r_tot) begin
                    n_diff = '0;
                    n_den  = DEN_W'(1);
                end else begin
                    n_diff = (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);
                    n_den  = DEN_W'(r_c) * DEN_W'(r_nc);
                end
                n_go    = 1'b1;
                n_state = ST_M1;
            end
            ST_M1: begin
                if (mul_done) begin
                    n_d2    = mul_prod[MC_W-1:0];
                    n_go    = 1'b1;
                    n_state = ST_M2;
                end
            end
            ST_M2: begin
                if (mul_done) begin
                    n_lhs   = mul_prod;
                    n_go    = 1'b1;
                    n_state = ST_M3;
                end
            end
            ST_M3: begin
                if (mul_done) begin
                    n_rhs   = mul_prod;
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (r_lhs > r_rhs) begin
                    n_best_d2  = r_d2;
                    n_best_den = r_den;
                    n_tsum     = TSUM_W'(r_k);
                    n_tcnt     = TCNT_W'(1);
                end else if (r_lhs == r_rhs) begin
                    n_tsum = r_tsum + TSUM_W'(r_k);
                    n_tcnt = r_tcnt + 1'b1;
                end
                n_k = r_k + 1'b1;
                if (r_k == BIN_W'(BIN_N - 1)) begin
                    n_q     = n_tsum;
                    n_rem   = '0;
                    n_k     = '0;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (div_sh >= {1'b0, r_tcnt}) begin
                    n_rem = div_sh - {1'b0, r_tcnt};
                    n_q   = {r_q[TSUM_W-2:0], 1'b1};
                end else begin
                    n_rem = div_sh;
                    n_q   = {r_q[TSUM_W-2:0], 1'b0};
                end
                n_k = r_k + 1'b1;
                if (r_k == BIN_W'(TSUM_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld = 1'b1;
                    n_thr     = r_ovf ? '0 : r_q[BIN_W-1:0];
                    n_oflag   = r_ovf;
                    n_tot     = '0;
                    n_isum    = '0;
                    n_ovf     = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_k       <= '0;
            r_tot     <= '0;
            r_isum    <= '0;
            r_ovf     <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_w_vld   <= 1'b0;
            r_go      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_tot     <= n_tot;
            r_isum    <= n_isum;
            r_ovf     <= n_ovf;
            r_s1_vld  <= n_s1_vld;
            r_w_vld   <= r_s1_vld;
            r_go      <= n_go;
            r_out_vld <= n_out_vld;
        end
        r_s1_addr  <= i_pixel;
        r_w_addr   <= r_s1_addr;
        r_w_data   <= bin_inc;
        r_c        <= n_c;
        r_s        <= n_s;
        r_a        <= n_a;
        r_b        <= n_b;
        r_nc       <= n_nc;
        r_diff     <= n_diff;
        r_den      <= n_den;
        r_d2       <= n_d2;
        r_lhs      <= n_lhs;
        r_rhs      <= n_rhs;
        r_best_d2  <= n_best_d2;
        r_best_den <= n_best_den;
        r_tsum     <= n_tsum;
        r_tcnt     <= n_tcnt;
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_thr      <= n_thr;
        r_oflag    <= n_oflag;
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_tcnt != '0))
        else $error("tie count is zero during division");

    a_ovf_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_threshold == '0))
        else $error("overflow result carries a nonzero threshold");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside the done state");

    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_state == ST_IDLE || r_state == ST_DRAIN))
        else $error("histogram increment overlaps the bin walk");
`endif
endmodule
